// ===== src/bsmm_pkg.sv =====
// Shared types and codes for the bounded stack with running min/max.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package bsmm_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PEEK_W   = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_PEEK  = 2'd3
  } status_e;

  // One stack level: the stored word and the min/max of it and all below.
  typedef struct packed {
    word_t entry;
    word_t lo;
    word_t hi;
  } lvl_t;

  // Shift command broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

`default_nettype wire

// ===== src/bsmm_req_if.sv =====
// Request channel of the stack: valid/ready plus op, push value, peek depth.
// Depends on bsmm_pkg for the field widths.
`default_nettype none

interface bsmm_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bsmm_pkg::OP_W-1:0]            op;
  logic signed [bsmm_pkg::WORD_W-1:0]   push_value;
  logic [bsmm_pkg::PEEK_W-1:0]          peek_depth;

  modport source (output valid, op, push_value, peek_depth, input ready);
  modport sink   (input valid, op, push_value, peek_depth, output ready);
endinterface

`default_nettype wire

// ===== src/bsmm_rsp_if.sv =====
// Response channel of the stack: valid/ready plus status, count, flags, data.
// Depends on bsmm_pkg for the field widths.
`default_nettype none

interface bsmm_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [bsmm_pkg::STATUS_W-1:0]        status;
  logic [bsmm_pkg::COUNT_W-1:0]         entry_count;
  logic                                 is_empty;
  logic                                 is_full;
  logic signed [bsmm_pkg::WORD_W-1:0]   top_value;
  logic signed [bsmm_pkg::WORD_W-1:0]   min_value;
  logic signed [bsmm_pkg::WORD_W-1:0]   max_value;
  logic signed [bsmm_pkg::WORD_W-1:0]   peek_value;

  modport source (output valid, status, entry_count, is_empty, is_full, top_value,
                  min_value, max_value, peek_value, input ready);
  modport sink   (input valid, status, entry_count, is_empty, is_full, top_value,
                  min_value, max_value, peek_value, output ready);
endinterface

`default_nettype wire

// ===== src/bsmm_cell.sv =====
// One stack level: holds a word with its running min/max, shifts to/from neighbors.
// Depends on bsmm_pkg.
`default_nettype none

module bsmm_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                          clk_i,
  input  wire bsmm_pkg::shift_t              shift_i,
  input  wire bsmm_pkg::lvl_t                upper_i,
  input  wire bsmm_pkg::lvl_t                lower_i,
  input  wire logic [bsmm_pkg::PEEK_W-1:0]   peek_depth_i,
  output bsmm_pkg::lvl_t                     lvl_o,
  output bsmm_pkg::word_t                    peek_o
);
  import bsmm_pkg::*;

  lvl_t lvl_q, lvl_d;

  // Push moves everything one level down, pop one level up.
  always_comb begin
    lvl_d = lvl_q;
    if (shift_i.push) begin
      lvl_d = upper_i;
    end else if (shift_i.pop) begin
      lvl_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
  end

  assign lvl_o  = lvl_q;
  // Drive the word onto the peek OR-bus only when this level is addressed.
  assign peek_o = (32'(peek_depth_i) == IDX) ? lvl_q.entry : '0;

endmodule

`default_nettype wire

// ===== src/bounded_stack_with_min_max_peek.sv =====
// Top level of the bounded LIFO stack with running min/max and peek.
// Depends on bsmm_pkg, bsmm_req_if, bsmm_rsp_if and bsmm_cell.
//
//   channel  dir  port   payload
//   request  in   req_i  op, push_value, peek_depth
//   response out  rsp_o  status, entry_count, is_empty, is_full, top, min, max, peek
//
// One request per cycle sustained while the response side takes results; a request
// transfer updates the cells and the middle stage, and the output register loads
// from the middle stage when that stage advances.
// The stack is a row of DEPTH cells, top at cell 0; each push or pop shifts the
// whole row by one level at once, so no scan and no memory port limits rate.
// Reset clears the count and valid flags only; cell contents are don't-care.
// A stalled response holds the request side: ready drops while a finished
// result waits in the middle stage and the output register is still occupied.
`default_nettype none

module bounded_stack_with_min_max_peek #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bsmm_req_if.sink   req_i,
  bsmm_rsp_if.source rsp_o
);
  import bsmm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > PEEK_W) ? CNT_W : PEEK_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // ---------------------------------------------------------------
  // Handshake and middle stage control
  // ---------------------------------------------------------------
  logic p_valid_q;
  logic adv;
  logic accept;

  assign adv         = p_valid_q && (!rsp_o.valid || rsp_o.ready);
  assign req_i.ready = !p_valid_q || adv;
  assign accept      = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------
  // Count and status
  // ---------------------------------------------------------------
  logic [CNT_W-1:0] count_q, count_d;
  status_e          status_d;
  shift_t           shift;
  logic             is_full_now;
  logic             is_empty_now;
  logic             pk_ok_d;

  assign is_full_now  = (count_q == FULL_CNT);
  assign is_empty_now = (count_q == '0);

  always_comb begin
    count_d    = count_q;
    status_d   = ST_OK;
    shift      = '0;
    case (op_e'(req_i.op))
      OP_PUSH: begin
        if (is_full_now) begin
          status_d = ST_FULL;
        end else begin
          shift.push = 1'b1;
          count_d    = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (is_empty_now) begin
          status_d = ST_EMPTY;
        end else begin
          shift.pop = 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      OP_PEEK: begin
        if (CMP_W'(req_i.peek_depth) >= CMP_W'(count_q)) begin
          status_d = ST_BAD_PEEK;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Peek is valid when the depth lies below the count after this request.
  assign pk_ok_d = CMP_W'(req_i.peek_depth) < CMP_W'(count_d);

  shift_t shift_en;
  assign shift_en.push = shift.push && accept;
  assign shift_en.pop  = shift.pop && accept;

  // ---------------------------------------------------------------
  // Cell row; the head record folds the new word into the running min/max
  // ---------------------------------------------------------------
  lvl_t  lvl_w  [DEPTH];
  word_t peek_w [DEPTH];
  lvl_t  head;
  lvl_t  tail;

  always_comb begin
    head.entry = req_i.push_value;
    if (is_empty_now) begin
      head.lo = req_i.push_value;
      head.hi = req_i.push_value;
    end else begin
      head.lo = (req_i.push_value < lvl_w[0].lo) ? req_i.push_value : lvl_w[0].lo;
      head.hi = (req_i.push_value > lvl_w[0].hi) ? req_i.push_value : lvl_w[0].hi;
    end
  end

  // Bottom level pulls in nothing meaningful on pop; it lies beyond the count.
  assign tail = '0;

  // Hold the peek depth of the request in flight for the output stage.
  logic [PEEK_W-1:0] p_pd_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bsmm_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .shift_i      (shift_en),
      .upper_i      ((i == 0) ? head : lvl_w[(i == 0) ? 0 : i - 1]),
      .lower_i      ((i == DEPTH - 1) ? tail : lvl_w[(i == DEPTH - 1) ? i : i + 1]),
      .peek_depth_i (p_pd_q),
      .lvl_o        (lvl_w[i]),
      .peek_o       (peek_w[i])
    );
  end

  // Gather the addressed level off the OR-bus.
  word_t peek_or;
  always_comb begin
    peek_or = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      peek_or = peek_or | peek_w[i];
    end
  end

  // ---------------------------------------------------------------
  // Middle stage: status and flags of the request whose cells just updated
  // ---------------------------------------------------------------
  status_e          p_status_q;
  logic             p_pk_ok_q;
  logic [CNT_W-1:0] p_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      count_q   <= '0;
    end else begin
      if (accept) begin
        p_valid_q <= 1'b1;
        count_q   <= count_d;
      end else if (adv) begin
        p_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_status_q <= status_d;
      p_pk_ok_q  <= pk_ok_d;
      p_count_q  <= count_d;
      p_pd_q     <= req_i.peek_depth;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic p_empty;
  assign p_empty = (p_count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_o.valid <= 1'b0;
    end else begin
      if (adv) begin
        rsp_o.valid <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_o.status      <= p_status_q;
      rsp_o.entry_count <= COUNT_W'(p_count_q);
      rsp_o.is_empty    <= p_empty;
      rsp_o.is_full     <= (p_count_q == FULL_CNT);
      rsp_o.top_value   <= p_empty ? '0 : lvl_w[0].entry;
      rsp_o.min_value   <= p_empty ? '0 : lvl_w[0].lo;
      rsp_o.max_value   <= p_empty ? '0 : lvl_w[0].hi;
      rsp_o.peek_value  <= p_pk_ok_q ? peek_or : '0;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("stack count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.op == OP_PUSH) && !is_full_now |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted push did not grow the count");

  a_min_max_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.is_empty |->
      (rsp_o.min_value <= rsp_o.top_value) && (rsp_o.top_value <= rsp_o.max_value))
    else $error("top outside running min/max");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> p_valid_q && rsp_o.valid && !rsp_o.ready)
    else $error("request side stalled without a blocked response");
`endif

endmodule

`default_nettype wire
